[hw/rtl/mavg_pkg.sv]
// Shared types and constants for the moving-average filter unit.
package mavg_pkg;

  // Field and configuration port widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned LEN_REG_W  = 6;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AVERAGE_MODE  = 2'd1;

  // Register reset values
  localparam logic [LEN_REG_W-1:0] LEN_RESET  = 6'd8;
  localparam logic                 MODE_RESET = 1'b0;

  // Averaging modes
  localparam logic MODE_SIMPLE   = 1'b0;
  localparam logic MODE_WEIGHTED = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_e;

  // Status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hw/rtl/mavg_win.sv]
// Window sample store with per-entry valid bits so unwritten entries read as zero.
module mavg_win #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rd_en_i,
  input  logic [IdxW-1:0]                    rd_addr_i,
  input  logic                               wr_en_i,
  input  logic [IdxW-1:0]                    wr_addr_i,
  input  logic [mavg_pkg::SAMPLE_W-1:0]      wr_data_i,
  output logic [mavg_pkg::SAMPLE_W-1:0]      rd_data_o
);

  logic [mavg_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]              valid_q;
  logic [mavg_pkg::SAMPLE_W-1:0] rd_data_q;
  logic                          rd_valid_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Mark entries as written; reset makes the whole window read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

[hw/rtl/mavg_div.sv]
// Bit-serial restoring divider for the signed window sum, one quotient bit per cycle.
module mavg_div #(
  parameter int unsigned ACC_W = 27,
  parameter int unsigned DIV_W = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [ACC_W-1:0]       dividend_i,
  input  logic [DIV_W-1:0]              divisor_i,
  output logic [mavg_pkg::SAMPLE_W-1:0] quotient_o,
  output mavg_pkg::div_stat_t           stat_o
);

  localparam int unsigned CntW = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] quo_q, quo_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] dsr_q;
  logic             neg_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [ACC_W-1:0] mag;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;
  logic             ge;
  logic [ACC_W-1:0] quo_signed;

  // Magnitude of the dividend; the most negative value still fits unsigned
  assign mag = dividend_i[ACC_W-1] ? (~dividend_i + ACC_W'(1)) : dividend_i;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem_q[DIV_W-1:0], quo_q[ACC_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    ge      = !diff[DIV_W+1];
    rem_d   = ge ? diff[DIV_W:0] : shifted;
    quo_d   = {quo_q[ACC_W-2:0], ge};
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      dsr_q <= divisor_i;
      neg_q <= dividend_i[ACC_W-1];
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // Iteration count and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntW'(ACC_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restore the sign; the quotient magnitude always fits the sample width
  assign quo_signed  = neg_q ? (~quo_q + ACC_W'(1)) : quo_q;
  assign quotient_o  = quo_signed[mavg_pkg::SAMPLE_W-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[hw/rtl/moving_average_filter_unit.sv]
// Top level of the moving-average filter: sequencer, window walk, accumulator, output register.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata[15:0] sample
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata[15:0] average
//  cfg       | in        | cfg_we_i (no wait)           | cfg_addr_i, cfg_wdata_i[5:0]
//
// A transaction first walks the window store (one read and one write port) over the N
// entries of the effective window length N, then the bit-serial divider produces an
// ACC_W-bit quotient (ACC_W = 27 at MAX_WINDOW = 32).
// Reset makes the whole window read as zero at once through per-entry valid bits.
// A new sample is taken while the previous average still waits on m_axis; a stalled
// m_axis holds the sequencer only when the next average is ready to be written.
module moving_average_filter_unit #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,   // [15:0] sample
  // Average stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [15:0]                         m_axis_tdata,   // [15:0] average
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [mavg_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [mavg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned IdxW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned LenW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DivMax = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
  localparam int unsigned DivW   = (DivMax > 1) ? $clog2(DivMax + 1) : 1;
  localparam int unsigned ProdW  = mavg_pkg::SAMPLE_W + LenW + 1;
  localparam int unsigned AccW   = mavg_pkg::SAMPLE_W + DivW + 1;

  mavg_pkg::state_e state_q, state_d;

  logic [mavg_pkg::LEN_REG_W-1:0] wlen_q;
  logic                           mode_q;
  logic [LenW-1:0]                n_q;
  logic                           wmode_q;
  logic [mavg_pkg::SAMPLE_W-1:0]  sample_q;
  logic [DivW-1:0]                divisor_q;
  logic [LenW-1:0]                cnt_q;
  logic signed [ProdW-1:0]        prod_q, prod_d;
  logic                           prod_vld_q;
  logic signed [AccW-1:0]         acc_q;
  logic                           m_tvalid_q;
  logic [mavg_pkg::SAMPLE_W-1:0]  m_tdata_q;

  int                             eff_int;
  logic [LenW-1:0]                eff_len;
  logic [DivW-1:0]                eff_divisor;
  logic                           in_acc;
  logic                           walk;
  logic                           rd_en;
  logic                           wr_en;
  logic                           walk_end;
  logic                           div_start;
  logic                           load_out;
  logic [IdxW-1:0]                rd_addr;
  logic [IdxW-1:0]                wr_addr;
  logic [LenW:0]                  cnt_inc;
  logic [LenW-1:0]                cnt_dec;
  logic [mavg_pkg::SAMPLE_W-1:0]  rd_data;
  logic [mavg_pkg::SAMPLE_W-1:0]  entry;
  logic [LenW-1:0]                weight;
  logic [mavg_pkg::SAMPLE_W-1:0]  quotient;
  mavg_pkg::div_stat_t            div_stat;

  // Clamp the configured length and derive the divisor for the chosen mode
  always_comb begin
    eff_int = int'(wlen_q);
    if (eff_int < 1) begin
      eff_int = 1;
    end
    if (eff_int > int'(MAX_WINDOW)) begin
      eff_int = int'(MAX_WINDOW);
    end
    eff_len = LenW'(eff_int);
    if (mode_q == mavg_pkg::MODE_WEIGHTED) begin
      eff_divisor = DivW'((eff_int * (eff_int + 1)) >> 1);
    end else begin
      eff_divisor = DivW'(eff_int);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= mavg_pkg::LEN_RESET;
      mode_q <= mavg_pkg::MODE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        mavg_pkg::REG_WINDOW_LENGTH: wlen_q <= cfg_wdata_i[mavg_pkg::LEN_REG_W-1:0];
        mavg_pkg::REG_AVERAGE_MODE:  mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mavg_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = mavg_pkg::ST_WALK;
      mavg_pkg::ST_WALK:  if (cnt_q == n_q) state_d = mavg_pkg::ST_FLUSH;
      mavg_pkg::ST_FLUSH: state_d = mavg_pkg::ST_START;
      mavg_pkg::ST_START: state_d = mavg_pkg::ST_DIV;
      mavg_pkg::ST_DIV:   if (div_stat.done) state_d = mavg_pkg::ST_OUT;
      mavg_pkg::ST_OUT:   if (!m_tvalid_q || m_axis_tready) state_d = mavg_pkg::ST_IDLE;
      default:            state_d = mavg_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    walk          = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      mavg_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      mavg_pkg::ST_WALK:  walk = 1'b1;
      mavg_pkg::ST_START: div_start = 1'b1;
      mavg_pkg::ST_OUT:   load_out = !m_tvalid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Window walk: read entry cnt+1 while writing entry cnt-1 with the value read before
  assign cnt_inc  = {1'b0, cnt_q} + (LenW + 1)'(1);
  assign cnt_dec  = cnt_q - LenW'(1);
  assign rd_en    = walk && (cnt_inc < {1'b0, n_q});
  assign wr_en    = walk && (cnt_q != '0);
  assign walk_end = (cnt_q == n_q);
  assign rd_addr  = cnt_inc[IdxW-1:0];
  assign wr_addr  = cnt_dec[IdxW-1:0];
  assign entry    = walk_end ? sample_q : rd_data;
  assign weight   = (wmode_q == mavg_pkg::MODE_WEIGHTED) ? cnt_q : LenW'(1);
  assign prod_d   = ProdW'($signed(entry)) * ProdW'($signed({1'b0, weight}));

  mavg_win #(
    .DEPTH (MAX_WINDOW)
  ) u_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (entry),
    .rd_data_o (rd_data)
  );

  // Latch the transaction and its settings at accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q  <= s_axis_tdata;
      n_q       <= eff_len;
      wmode_q   <= mode_q;
      divisor_q <= eff_divisor;
    end
    prod_q <= prod_d;
  end

  // Walk counter, product pipeline and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mavg_pkg::ST_IDLE;
      cnt_q      <= '0;
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      state_q    <= state_d;
      prod_vld_q <= wr_en;
      if (in_acc) begin
        cnt_q <= '0;
        acc_q <= '0;
      end else begin
        if (walk) begin
          cnt_q <= cnt_q + LenW'(1);
        end
        if (prod_vld_q) begin
          acc_q <= acc_q + AccW'(prod_q);
        end
      end
    end
  end

  mavg_div #(
    .ACC_W (AccW),
    .DIV_W (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (divisor_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // Output register: hold the average until the transaction completes
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_tdata_q <= quotient;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (load_out) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // The divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == mavg_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  // The walk never runs past the latched window length
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mavg_pkg::ST_WALK |-> cnt_q <= n_q)
    else $error("window walk ran past the window length");

  // An accepted sample always starts a window walk
  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == mavg_pkg::ST_WALK && cnt_q == '0)
    else $error("accepted sample did not start a walk");

  // A new average appears only when the sequencer hands one over
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q) == mavg_pkg::ST_OUT)
    else $error("average presented without a finished division");

endmodule
